FILE: sv/cfe_pkg.sv
// Package for the cavity free-energy accumulator: constants, types and helpers.
`default_nettype none

package cfe_pkg;

    // Default number of squaring steps in the log2 evaluation
    localparam int unsigned LOG_ITERATIONS = 24;

    // Field widths
    localparam int unsigned RADIUS_W = 14;
    localparam int unsigned AREA_W   = 18;
    localparam int unsigned ENERGY_W = 40;
    localparam int unsigned CFG_W    = 24;

    // Saturation bounds and fixed-point constants
    localparam logic signed [63:0] LIM        = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] C48        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE32      = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] RGAS_Q12   = 64'sd34056;
    localparam logic signed [63:0] NPIP_Q40   = 64'sd2080178;
    localparam logic signed [63:0] PI6_Q32    = 64'sd2248839617;
    localparam logic signed [63:0] LN2_Q32    = 64'sd2977044472;
    localparam logic signed [63:0] INV4PI_Q48 = 64'sd22399066950;
    localparam logic signed [63:0] ENERGY_MAX = 64'sh0000_007F_FFFF_FFFF;
    localparam logic signed [63:0] ENERGY_MIN = 64'shFFFF_FF80_0000_0000;

    // Register reset values
    localparam logic [13:0] PROBE_R_RST        = 14'd5673;
    localparam logic [15:0] NUMBER_DENSITY_RST = 16'd34944;
    localparam logic [23:0] PRESSURE_PA_RST    = 24'd101325;
    localparam logic [13:0] TEMPERATURE_RST    = 14'd4768;

    typedef enum logic [1:0] {
        CFG_PROBE_R,
        CFG_NUMBER_DENSITY,
        CFG_PRESSURE_PA,
        CFG_TEMPERATURE
    } cfg_index_t;

    typedef struct packed {
        logic [13:0] probe_r;
        logic [15:0] number_density;
        logic [23:0] pressure_pa;
        logic [13:0] temperature;
    } cfg_t;

    // Shared multiply/divide unit request: round (or truncate) a*b / (d * 2^sh)
    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0]        d;
        logic [5:0]         sh;
        logic               trunc;
    } fx_req_t;

    typedef struct packed {
        logic                        valid;
        logic signed [ENERGY_W-1:0]  energy;
        logic                        error_flag;
    } result_t;

    typedef enum logic [2:0] {
        FX_IDLE,
        FX_MUL,
        FX_BIAS,
        FX_DIV,
        FX_SHIFT,
        FX_SAT
    } fx_phase_t;

    typedef enum logic [5:0] {
        SQ_IDLE,
        SQ_S2, SQ_S3, SQ_NKT, SQ_NP, SQ_YRAW, SQ_Y, SQ_YCHK,
        SQ_YF, SQ_YF2, SQ_LNORM, SQ_LSQ, SQ_LOGV,
        SQ_A0, SQ_A1A, SQ_A1B, SQ_A2, SQ_T1, SQ_T2,
        SQ_C0A, SQ_C0B, SQ_C1, SQ_C2, SQ_C3,
        SQ_QCHK, SQ_QQ, SQ_G0, SQ_G1, SQ_G3, SQ_GA, SQ_E,
        SQ_END, SQ_OUT, SQ_EMIT
    } seq_state_t;

    // Sum of two values within +-LIM, saturated to +-LIM
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > LIM)
            return LIM;
        else if (s < -LIM)
            return -LIM;
        else
            return s;
    endfunction

    // Clamp to the coefficient range
    function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > C48)
            c = C48;
        else if (v < -C48)
            c = -C48;
        else
            c = v;
        return c[47:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/cfe_in_if.sv
// Atom input channel: valid/ready with radius, area and last marker.
`default_nettype none

interface cfe_in_if;
    logic        valid;
    logic        ready;
    logic [13:0] atom_radius;
    logic [17:0] atom_area;
    logic        last_atom;

    modport source (output valid, atom_radius, atom_area, last_atom, input ready);
    modport sink   (input valid, atom_radius, atom_area, last_atom, output ready);
endinterface

`default_nettype wire

FILE: sv/cfe_out_if.sv
// Result channel: valid/ready with total energy and error flag.
`default_nettype none

interface cfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] energy;
    logic               error_flag;

    modport source (output valid, energy, error_flag, input ready);
    modport sink   (input valid, energy, error_flag, output ready);
endinterface

`default_nettype wire

FILE: sv/cfe_fx.sv
// Bit-serial multiply, round, divide and saturate unit.
`default_nettype none

module cfe_fx (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire cfe_pkg::fx_req_t req,
    output logic                 done,
    output logic signed [63:0]   res
);

    cfe_pkg::fx_phase_t phase_reg, phase_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [63:0]  ua_reg, ua_next;
    logic [63:0]  d_reg, d_next;
    logic [5:0]   sh_reg, sh_next;
    logic         trunc_reg, trunc_next;
    logic         neg_reg, neg_next;
    logic [127:0] p_reg, p_next;
    logic [63:0]  r_reg, r_next;
    logic         done_reg, done_next;
    logic signed [63:0] res_reg, res_next;

    logic [64:0]  msum;
    logic [127:0] bias;
    logic [64:0]  rs;
    logic         ge;
    logic [63:0]  mag;

    // Phase sequencing and datapath
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ua_next    = ua_reg;
        d_next     = d_reg;
        sh_next    = sh_reg;
        trunc_next = trunc_reg;
        neg_next   = neg_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        msum = {1'b0, p_reg[127:64]} + {1'b0, (p_reg[0] ? ua_reg : 64'd0)};
        if (trunc_reg)
            bias = '0;
        else if (sh_reg == 6'd0)
            bias = {65'd0, d_reg[63:1]};
        else
            bias = {64'd0, d_reg} << (sh_reg - 6'd1);
        rs  = {r_reg, p_reg[127]};
        ge  = (rs >= {1'b0, d_reg});
        mag = (|p_reg[127:62]) ? cfe_pkg::LIM : p_reg[63:0];

        unique case (phase_reg)
            cfe_pkg::FX_IDLE:
            begin
                if (start)
                begin
                    neg_next   = req.a[63] ^ req.b[63];
                    ua_next    = req.a[63] ? 64'(-req.a) : req.a;
                    p_next     = {64'd0, (req.b[63] ? 64'(-req.b) : req.b)};
                    d_next     = req.d;
                    sh_next    = req.sh;
                    trunc_next = req.trunc;
                    cnt_next   = 7'd63;
                    phase_next = cfe_pkg::FX_MUL;
                end
            end
            // One multiplier bit per cycle, shift-add
            cfe_pkg::FX_MUL:
            begin
                p_next = {msum, p_reg[63:1]};
                if (cnt_reg == 7'd0)
                    phase_next = cfe_pkg::FX_BIAS;
                else
                    cnt_next = cnt_reg - 7'd1;
            end
            // Rounding offset, then skip the divide where the divisor is trivial
            cfe_pkg::FX_BIAS:
            begin
                p_next = p_reg + bias;
                if (d_reg == 64'd0)
                begin
                    p_next     = '0;
                    phase_next = cfe_pkg::FX_SAT;
                end
                else if (d_reg == 64'd1)
                begin
                    cnt_next   = {1'b0, sh_reg};
                    phase_next = cfe_pkg::FX_SHIFT;
                end
                else
                begin
                    cnt_next   = 7'd127;
                    r_next     = '0;
                    phase_next = cfe_pkg::FX_DIV;
                end
            end
            // Restoring divide, one quotient bit per cycle
            cfe_pkg::FX_DIV:
            begin
                r_next = ge ? 64'(rs - {1'b0, d_reg}) : rs[63:0];
                p_next = {p_reg[126:0], ge};
                if (cnt_reg == 7'd0)
                begin
                    cnt_next   = {1'b0, sh_reg};
                    phase_next = cfe_pkg::FX_SHIFT;
                end
                else
                    cnt_next = cnt_reg - 7'd1;
            end
            cfe_pkg::FX_SHIFT:
            begin
                if (cnt_reg == 7'd0)
                    phase_next = cfe_pkg::FX_SAT;
                else
                begin
                    p_next   = {1'b0, p_reg[127:1]};
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            cfe_pkg::FX_SAT:
            begin
                res_next   = neg_reg ? 64'(-mag) : mag;
                done_next  = 1'b1;
                phase_next = cfe_pkg::FX_IDLE;
            end
            default:
                phase_next = cfe_pkg::FX_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfe_pkg::FX_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        ua_reg    <= ua_next;
        d_reg     <= d_next;
        sh_reg    <= sh_next;
        trunc_reg <= trunc_next;
        neg_reg   <= neg_next;
        p_reg     <= p_next;
        r_reg     <= r_next;
        res_reg   <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

FILE: sv/cfe_seq.sv
// Sequencer: coefficient setup, per-atom evaluation and accumulation.
`default_nettype none

module cfe_seq #(
    parameter int unsigned LOG_ITERATIONS = cfe_pkg::LOG_ITERATIONS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfe_pkg::cfg_t cfg,
    input  wire logic          item_start,
    input  wire logic [13:0]   atom_radius,
    input  wire logic [17:0]   atom_area,
    input  wire logic          last_atom,
    input  wire logic          out_free,
    output logic               idle,
    output cfe_pkg::result_t   result
);

    localparam int unsigned IterW = $clog2(LOG_ITERATIONS + 1);

    cfe_pkg::seq_state_t state_reg, state_next;
    logic busy_reg, busy_next;
    logic ready_reg, ready_next;
    logic err_reg, err_next;
    logic [13:0] radius_reg, radius_next;
    logic [17:0] area_reg, area_next;
    logic last_reg, last_next;
    logic signed [63:0] s2_reg, s2_next, s3_reg, s3_next, nkt_reg, nkt_next;
    logic signed [63:0] np_reg, np_next, tmp_reg, tmp_next, u_reg, u_next;
    logic signed [63:0] y_reg, y_next, yf_reg, yf_next, yf2_reg, yf2_next;
    logic signed [63:0] a0_reg, a0_next, a1_reg, a1_next, a2_reg, a2_next;
    logic signed [63:0] t1_reg, t1_next, t2_reg, t2_next, logv_reg, logv_next;
    logic signed [63:0] g_reg, g_next, sum_reg, sum_next;
    logic signed [47:0] c0_reg, c0_next, c1_reg, c1_next;
    logic signed [47:0] c2_reg, c2_next, c3_reg, c3_next;
    logic [32:0] xn_reg, xn_next;
    logic [5:0]  k_reg, k_next;
    logic [31:0] m_reg, m_next;
    logic [47:0] f_reg, f_next;
    logic [IterW-1:0] iter_reg, iter_next;
    cfe_pkg::result_t result_reg, result_next;

    cfe_pkg::fx_req_t fx_req;
    logic fx_start, fx_need, fx_done;
    logic signed [63:0] fx_res;
    logic signed [63:0] s, qw, c0w, c1w, c2w, c3w, ev;
    logic [14:0] q;
    logic [31:0] mm;
    logic [5:0]  fidx;

    cfe_fx u_fx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fx_start),
        .req   (fx_req),
        .done  (fx_done),
        .res   (fx_res)
    );

    assign s    = {49'd0, cfg.probe_r, 1'b0};
    assign q    = {1'b0, radius_reg} + {1'b0, cfg.probe_r};
    assign qw   = {49'd0, q};
    assign c0w  = {{16{c0_reg[47]}}, c0_reg};
    assign c1w  = {{16{c1_reg[47]}}, c1_reg};
    assign c2w  = {{16{c2_reg[47]}}, c2_reg};
    assign c3w  = {{16{c3_reg[47]}}, c3_reg};
    assign mm   = fx_res[31:0];
    assign fidx = 6'd48 - 6'(iter_reg);

    // Next state, unit requests and register updates
    always_comb
    begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        err_next    = err_reg;
        radius_next = radius_reg;
        area_next   = area_reg;
        last_next   = last_reg;
        s2_next = s2_reg; s3_next = s3_reg; nkt_next = nkt_reg; np_next = np_reg;
        tmp_next = tmp_reg; u_next = u_reg; y_next = y_reg; yf_next = yf_reg;
        yf2_next = yf2_reg; a0_next = a0_reg; a1_next = a1_reg; a2_next = a2_reg;
        t1_next = t1_reg; t2_next = t2_reg; logv_next = logv_reg;
        g_next = g_reg; sum_next = sum_reg;
        c0_next = c0_reg; c1_next = c1_reg; c2_next = c2_reg; c3_next = c3_reg;
        xn_next = xn_reg; k_next = k_reg; m_next = m_reg; f_next = f_reg;
        iter_next   = iter_reg;
        result_next = '0;
        idle        = 1'b0;
        fx_need     = 1'b0;
        fx_req      = '{a: 64'sd0, b: 64'sd0, d: 64'd1, sh: 6'd0, trunc: 1'b0};
        ev          = tmp_reg;

        unique case (state_reg)
            cfe_pkg::SQ_IDLE:
            begin
                idle = 1'b1;
                if (item_start)
                begin
                    radius_next = atom_radius;
                    area_next   = atom_area;
                    last_next   = last_atom;
                    t1_next     = '0;
                    t2_next     = '0;
                    state_next  = ready_reg ? cfe_pkg::SQ_QCHK : cfe_pkg::SQ_S2;
                end
            end
            // Probe powers, NkT and N*pi*P
            cfe_pkg::SQ_S2:
            begin
                fx_need = 1'b1;
                fx_req.a = s; fx_req.b = s;
                if (fx_done) begin s2_next = fx_res; state_next = cfe_pkg::SQ_S3; end
            end
            cfe_pkg::SQ_S3:
            begin
                fx_need = 1'b1;
                fx_req.a = s2_reg; fx_req.b = s;
                if (fx_done) begin s3_next = fx_res; state_next = cfe_pkg::SQ_NKT; end
            end
            cfe_pkg::SQ_NKT:
            begin
                fx_need = 1'b1;
                fx_req.a = {50'd0, cfg.temperature}; fx_req.b = cfe_pkg::RGAS_Q12;
                if (fx_done) begin nkt_next = fx_res; state_next = cfe_pkg::SQ_NP; end
            end
            cfe_pkg::SQ_NP:
            begin
                fx_need = 1'b1;
                fx_req.a = {40'd0, cfg.pressure_pa}; fx_req.b = cfe_pkg::NPIP_Q40;
                if (fx_done) begin np_next = fx_res; state_next = cfe_pkg::SQ_YRAW; end
            end
            // Packing fraction
            cfe_pkg::SQ_YRAW:
            begin
                fx_need = 1'b1;
                fx_req.a = s3_reg; fx_req.b = {48'd0, cfg.number_density};
                if (fx_done) begin tmp_next = fx_res; state_next = cfe_pkg::SQ_Y; end
            end
            cfe_pkg::SQ_Y:
            begin
                fx_need = 1'b1;
                fx_req.a = tmp_reg; fx_req.b = cfe_pkg::PI6_Q32; fx_req.sh = 6'd56;
                if (fx_done) begin y_next = fx_res; state_next = cfe_pkg::SQ_YCHK; end
            end
            cfe_pkg::SQ_YCHK:
            begin
                if (y_reg >= cfe_pkg::ONE32)
                begin
                    err_next   = 1'b1;
                    ready_next = 1'b1;
                    c0_next = '0; c1_next = '0; c2_next = '0; c3_next = '0;
                    state_next = cfe_pkg::SQ_QCHK;
                end
                else
                    state_next = cfe_pkg::SQ_YF;
            end
            cfe_pkg::SQ_YF:
            begin
                fx_need = 1'b1;
                fx_req.a = y_reg; fx_req.b = cfe_pkg::ONE32;
                fx_req.d = 64'(cfe_pkg::ONE32 - y_reg);
                if (fx_done) begin yf_next = fx_res; state_next = cfe_pkg::SQ_YF2; end
            end
            cfe_pkg::SQ_YF2:
            begin
                fx_need = 1'b1;
                fx_req.a = yf_reg; fx_req.b = yf_reg; fx_req.sh = 6'd32;
                if (fx_done)
                begin
                    yf2_next   = fx_res;
                    xn_next    = 33'(cfe_pkg::ONE32 - y_reg);
                    k_next     = '0;
                    state_next = cfe_pkg::SQ_LNORM;
                end
            end
            // Normalize 1-y, one bit per cycle
            cfe_pkg::SQ_LNORM:
            begin
                if (xn_reg[32])
                begin
                    m_next     = {1'b0, xn_reg[32:2]};
                    f_next     = '0;
                    iter_next  = IterW'(1);
                    state_next = cfe_pkg::SQ_LSQ;
                end
                else
                begin
                    xn_next = {xn_reg[31:0], 1'b0};
                    k_next  = k_reg + 6'd1;
                end
            end
            // Square the mantissa, one fraction bit per step
            cfe_pkg::SQ_LSQ:
            begin
                fx_need = 1'b1;
                fx_req.a = {32'd0, m_reg}; fx_req.b = {32'd0, m_reg};
                fx_req.sh = 6'd30; fx_req.trunc = 1'b1;
                if (fx_done)
                begin
                    if (mm[31])
                    begin
                        f_next[fidx] = 1'b1;
                        m_next       = {1'b0, mm[31:1]};
                    end
                    else
                        m_next = mm;
                    if (iter_reg == IterW'(LOG_ITERATIONS))
                        state_next = cfe_pkg::SQ_LOGV;
                    else
                        iter_next = iter_reg + IterW'(1);
                end
            end
            cfe_pkg::SQ_LOGV:
            begin
                fx_need = 1'b1;
                fx_req.a  = ({58'd0, k_reg} << 48) - {16'd0, f_reg};
                fx_req.b  = cfe_pkg::LN2_Q32;
                fx_req.sh = 6'd48;
                if (fx_done) begin logv_next = fx_res; state_next = cfe_pkg::SQ_A0; end
            end
            // Series terms
            cfe_pkg::SQ_A0:
            begin
                fx_need = 1'b1;
                fx_req.a = yf2_reg; fx_req.b = 64'sd9; fx_req.sh = 6'd1;
                if (fx_done)
                begin
                    a0_next    = cfe_pkg::sat_add(logv_reg, fx_res);
                    state_next = cfe_pkg::SQ_A1A;
                end
            end
            cfe_pkg::SQ_A1A:
            begin
                fx_need = 1'b1;
                fx_req.a = yf_reg; fx_req.b = 64'sd6;
                if (fx_done) begin tmp_next = fx_res; state_next = cfe_pkg::SQ_A1B; end
            end
            cfe_pkg::SQ_A1B:
            begin
                fx_need = 1'b1;
                fx_req.a = yf2_reg; fx_req.b = 64'sd18;
                if (fx_done)
                begin
                    u_next     = fx_res;
                    a1_next    = cfe_pkg::sat_add(tmp_reg, fx_res);
                    state_next = cfe_pkg::SQ_A2;
                end
            end
            cfe_pkg::SQ_A2:
            begin
                fx_need = 1'b1;
                fx_req.a = yf_reg; fx_req.b = 64'sd12;
                if (fx_done)
                begin
                    a2_next    = cfe_pkg::sat_add(fx_res, u_reg);
                    state_next = (s == 64'sd0) ? cfe_pkg::SQ_C0A : cfe_pkg::SQ_T1;
                end
            end
            cfe_pkg::SQ_T1:
            begin
                fx_need = 1'b1;
                fx_req.a = nkt_reg; fx_req.b = a1_reg; fx_req.sh = 6'd12; fx_req.d = s;
                if (fx_done) begin t1_next = fx_res; state_next = cfe_pkg::SQ_T2; end
            end
            cfe_pkg::SQ_T2:
            begin
                fx_need = 1'b1;
                fx_req.a = nkt_reg; fx_req.b = a2_reg; fx_req.d = s2_reg;
                if (fx_done) begin t2_next = fx_res; state_next = cfe_pkg::SQ_C0A; end
            end
            // Coefficients
            cfe_pkg::SQ_C0A:
            begin
                fx_need = 1'b1;
                fx_req.a = np_reg; fx_req.b = s3_reg; fx_req.sh = 6'd52; fx_req.d = 64'd6;
                if (fx_done) begin tmp_next = fx_res; state_next = cfe_pkg::SQ_C0B; end
            end
            cfe_pkg::SQ_C0B:
            begin
                fx_need = 1'b1;
                fx_req.a = nkt_reg; fx_req.b = a0_reg; fx_req.sh = 6'd24;
                if (fx_done)
                begin
                    c0_next    = cfe_pkg::clamp48(fx_res - tmp_reg);
                    state_next = cfe_pkg::SQ_C1;
                end
            end
            cfe_pkg::SQ_C1:
            begin
                fx_need = 1'b1;
                fx_req.a = np_reg; fx_req.b = s2_reg; fx_req.sh = 6'd40;
                if (fx_done)
                begin
                    c1_next    = cfe_pkg::clamp48(-(t1_reg + fx_res));
                    state_next = cfe_pkg::SQ_C2;
                end
            end
            cfe_pkg::SQ_C2:
            begin
                fx_need = 1'b1;
                fx_req.a = np_reg <<< 1; fx_req.b = s; fx_req.sh = 6'd28;
                if (fx_done)
                begin
                    c2_next    = cfe_pkg::clamp48(t2_reg - fx_res);
                    state_next = cfe_pkg::SQ_C3;
                end
            end
            cfe_pkg::SQ_C3:
            begin
                fx_need = 1'b1;
                fx_req.a = np_reg; fx_req.b = 64'sd4; fx_req.sh = 6'd16; fx_req.d = 64'd3;
                if (fx_done)
                begin
                    c3_next    = cfe_pkg::clamp48(fx_res);
                    ready_next = 1'b1;
                    state_next = cfe_pkg::SQ_QCHK;
                end
            end
            // Per-atom cubic
            cfe_pkg::SQ_QCHK:
            begin
                if (q == 15'd0)
                begin
                    err_next   = 1'b1;
                    state_next = cfe_pkg::SQ_END;
                end
                else
                    state_next = cfe_pkg::SQ_QQ;
            end
            cfe_pkg::SQ_QQ:
            begin
                fx_need = 1'b1;
                fx_req.a = qw; fx_req.b = qw;
                if (fx_done) begin tmp_next = fx_res; state_next = cfe_pkg::SQ_G0; end
            end
            cfe_pkg::SQ_G0:
            begin
                fx_need = 1'b1;
                fx_req.a = c0w; fx_req.b = 64'sd16777216; fx_req.d = 64'(tmp_reg);
                if (fx_done) begin g_next = fx_res; state_next = cfe_pkg::SQ_G1; end
            end
            cfe_pkg::SQ_G1:
            begin
                fx_need = 1'b1;
                fx_req.a = c1w; fx_req.b = 64'sd4096; fx_req.d = 64'(qw);
                if (fx_done)
                begin
                    g_next     = cfe_pkg::sat_add(cfe_pkg::sat_add(g_reg, fx_res), c2w);
                    state_next = cfe_pkg::SQ_G3;
                end
            end
            cfe_pkg::SQ_G3:
            begin
                fx_need = 1'b1;
                fx_req.a = c3w; fx_req.b = qw; fx_req.sh = 6'd12;
                if (fx_done)
                begin
                    g_next     = cfe_pkg::sat_add(g_reg, fx_res);
                    state_next = cfe_pkg::SQ_GA;
                end
            end
            cfe_pkg::SQ_GA:
            begin
                fx_need = 1'b1;
                fx_req.a = g_reg; fx_req.b = {46'd0, area_reg}; fx_req.sh = 6'd8;
                if (fx_done) begin tmp_next = fx_res; state_next = cfe_pkg::SQ_E; end
            end
            cfe_pkg::SQ_E:
            begin
                fx_need = 1'b1;
                fx_req.a = tmp_reg; fx_req.b = cfe_pkg::INV4PI_Q48; fx_req.sh = 6'd48;
                if (fx_done)
                begin
                    sum_next   = cfe_pkg::sat_add(sum_reg, fx_res);
                    state_next = cfe_pkg::SQ_END;
                end
            end
            cfe_pkg::SQ_END:
            begin
                if (!last_reg)
                    state_next = cfe_pkg::SQ_IDLE;
                else if (err_reg)
                    state_next = cfe_pkg::SQ_EMIT;
                else
                    state_next = cfe_pkg::SQ_OUT;
            end
            // Round the total to the output scale
            cfe_pkg::SQ_OUT:
            begin
                fx_need = 1'b1;
                fx_req.a = sum_reg; fx_req.b = 64'sd1; fx_req.sh = 6'd8;
                if (fx_done) begin tmp_next = fx_res; state_next = cfe_pkg::SQ_EMIT; end
            end
            cfe_pkg::SQ_EMIT:
            begin
                if (tmp_reg > cfe_pkg::ENERGY_MAX)
                    ev = cfe_pkg::ENERGY_MAX;
                else if (tmp_reg < cfe_pkg::ENERGY_MIN)
                    ev = cfe_pkg::ENERGY_MIN;
                if (out_free)
                begin
                    result_next.valid      = 1'b1;
                    result_next.energy     = err_reg ? '0 : ev[39:0];
                    result_next.error_flag = err_reg;
                    sum_next   = '0;
                    err_next   = 1'b0;
                    ready_next = 1'b0;
                    state_next = cfe_pkg::SQ_IDLE;
                end
            end
            default:
                state_next = cfe_pkg::SQ_IDLE;
        endcase
    end

    // Launch the unit once per arithmetic state and per squaring step
    assign fx_start  = fx_need && !busy_reg;
    assign busy_next = fx_done ? 1'b0 : (fx_start ? 1'b1 : busy_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cfe_pkg::SQ_IDLE;
            busy_reg   <= 1'b0;
            ready_reg  <= 1'b0;
            err_reg    <= 1'b0;
            sum_reg    <= '0;
            c0_reg     <= '0;
            c1_reg     <= '0;
            c2_reg     <= '0;
            c3_reg     <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            ready_reg  <= ready_next;
            err_reg    <= err_next;
            sum_reg    <= sum_next;
            c0_reg     <= c0_next;
            c1_reg     <= c1_next;
            c2_reg     <= c2_next;
            c3_reg     <= c3_next;
            result_reg <= result_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        radius_reg <= radius_next;
        area_reg   <= area_next;
        last_reg   <= last_next;
        s2_reg <= s2_next; s3_reg <= s3_next; nkt_reg <= nkt_next; np_reg <= np_next;
        tmp_reg <= tmp_next; u_reg <= u_next; y_reg <= y_next; yf_reg <= yf_next;
        yf2_reg <= yf2_next; a0_reg <= a0_next; a1_reg <= a1_next; a2_reg <= a2_next;
        t1_reg <= t1_next; t2_reg <= t2_next; logv_reg <= logv_next; g_reg <= g_next;
        xn_reg <= xn_next; k_reg <= k_next; m_reg <= m_next; f_reg <= f_next;
        iter_reg <= iter_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: sv/cavity_free_energy_accumulator.sv
// Each atom takes six passes through the bit-serial unit; the last atom of a molecule
// adds a pass for output rounding before the result. The first atom of a molecule
// adds the coefficient setup, including the squaring steps of the logarithm; each
// pass runs a bit-serial multiply, a divide when the divisor is neither zero nor one,
// a right shift of one bit per cycle and a saturation step. One atom in work at a time.
// Reset: asynchronous active low, control and configuration registers to defaults.
`default_nettype none

module cavity_free_energy_accumulator #(
    parameter int unsigned LOG_ITERATIONS = cfe_pkg::LOG_ITERATIONS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cfe_in_if.sink           atoms,
    cfe_out_if.source        totals,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);

    cfe_pkg::cfg_t    cfg_reg, cfg_next;
    cfe_pkg::result_t seq_result;
    logic             seq_idle;
    logic             out_free;
    logic             out_valid_reg, out_valid_next;
    logic signed [39:0] energy_reg, energy_next;
    logic             err_reg, err_next;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfe_pkg::cfg_index_t'(cfg_index))
                cfe_pkg::CFG_PROBE_R:        cfg_next.probe_r        = cfg_wdata[13:0];
                cfe_pkg::CFG_NUMBER_DENSITY: cfg_next.number_density = cfg_wdata[15:0];
                cfe_pkg::CFG_PRESSURE_PA:    cfg_next.pressure_pa    = cfg_wdata;
                cfe_pkg::CFG_TEMPERATURE:    cfg_next.temperature    = cfg_wdata[13:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    cfe_seq #(
        .LOG_ITERATIONS (LOG_ITERATIONS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_start  (atoms.valid && atoms.ready),
        .atom_radius (atoms.atom_radius),
        .atom_area   (atoms.atom_area),
        .last_atom   (atoms.last_atom),
        .out_free    (out_free),
        .idle        (seq_idle),
        .result      (seq_result)
    );

    assign atoms.ready = seq_idle;
    assign out_free    = !out_valid_reg || totals.ready;

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        energy_next    = energy_reg;
        err_next       = err_reg;
        if (seq_result.valid)
        begin
            out_valid_next = 1'b1;
            energy_next    = seq_result.energy;
            err_next       = seq_result.error_flag;
        end
        else if (totals.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{probe_r:        cfe_pkg::PROBE_R_RST,
                               number_density: cfe_pkg::NUMBER_DENSITY_RST,
                               pressure_pa:    cfe_pkg::PRESSURE_PA_RST,
                               temperature:    cfe_pkg::TEMPERATURE_RST};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        err_reg    <= err_next;
    end

    assign totals.valid      = out_valid_reg;
    assign totals.energy     = energy_reg;
    assign totals.error_flag = err_reg;

`ifndef SYNTHESIS
    // A result is only handed over when the output register can take it
    a_result_fits: assert property (@(posedge clk) disable iff (!rst_n)
        seq_result.valid |-> out_free)
        else $error("result dropped: output register busy");

    // One atom in work at a time
    a_one_atom: assert property (@(posedge clk) disable iff (!rst_n)
        (atoms.valid && atoms.ready) |=> !atoms.ready)
        else $error("input accepted while atom in work");

    // Error results carry zero energy
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (totals.valid && totals.error_flag) |-> (totals.energy == '0))
        else $error("error result with nonzero energy");
`endif

endmodule

`default_nettype wire
